>>> hdl/ksc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ksc_pkg
// Shared types and constants of the kernel slot cache: field widths, boundary
// codes, result status codes, the controller command set and the slot entry.
// ============================================================================
package ksc_pkg;

    // Field widths
    localparam int DIM_W      = 11;
    localparam int RANK_W     = 2;
    localparam int BND_W      = 2;
    localparam int REF_W      = 5;
    localparam int CFG_W      = 5;
    localparam int USE_W      = 8;
    localparam int SIZE_W     = 30;
    localparam int TOTAL_W    = 34;
    localparam int SLOT_OUT_W = 4;

    // Boundary codes
    localparam logic [BND_W-1:0] BND_PERIODIC = 2'd0;
    localparam logic [BND_W-1:0] BND_TOP_ISO  = 2'd1;
    localparam logic [BND_W-1:0] BND_SUB_ISO  = 2'd2;
    localparam logic [BND_W-1:0] BND_UNDEF    = 2'd3;

    // Request codes and limits
    localparam logic              OP_RELEASE = 1'b1;
    localparam logic [REF_W-1:0]  REF_UNIT   = 5'd1;
    localparam logic [USE_W-1:0]  USE_MAX    = 8'hFF;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 30'h3FFF_FFFF;
    localparam logic [CFG_W-1:0]  CFG_RESET  = 5'd16;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_NO_FREE = 3'd2,
        ST_NO_CAP  = 3'd3,
        ST_BAD_BND = 3'd4,
        ST_BAD_REF = 3'd5,
        ST_RELEASE = 3'd6
    } t_status;

    // Commands from the controller to the datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_HSTART,
        CMD_HSCAN,
        CMD_FSTART,
        CMD_FSCAN,
        CMD_HIT_WRITE,
        CMD_REL_READ,
        CMD_REL_WRITE,
        CMD_EVICT,
        CMD_CLAIM,
        CMD_NO_FREE,
        CMD_NO_CAP,
        CMD_PUSH
    } t_cmd;

    // Status flags from the datapath to the controller
    typedef struct packed {
        logic is_release;
        logic bnd_undef;
        logic act_zero;
        logic found;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

    // One slot of the cache
    typedef struct packed {
        logic [BND_W-1:0]  boundary;
        logic [DIM_W-1:0]  dim_x;
        logic [DIM_W-1:0]  dim_y;
        logic [DIM_W-1:0]  dim_z;
        logic [USE_W-1:0]  use_count;
        logic [SIZE_W-1:0] size;
    } t_entry;

endpackage

>>> hdl/ksc_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// ksc_ctrl
// Sequencer of the slot cache: takes one request at a time and steps the
// datapath through hit scan, free-slot walk, claim or release, then hands
// the result to the output register.
// ============================================================================
module ksc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ksc_pkg::t_dp_stat  i_stat,
    output ksc_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_HSCAN,
        S_WRAP,
        S_FSCAN,
        S_HIT_WR,
        S_REL_WR,
        S_EVICT,
        S_CLAIM,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;

    // Next state and command
    always_comb begin
        n_state = r_state;
        o_cmd   = ksc_pkg::CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_stall) begin
                    o_cmd   = ksc_pkg::CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_release) begin
                    o_cmd   = ksc_pkg::CMD_REL_READ;
                    n_state = S_REL_WR;
                end else if (i_stat.act_zero) begin
                    o_cmd   = ksc_pkg::CMD_NO_CAP;
                    n_state = S_DONE;
                end else if (i_stat.bnd_undef) begin
                    n_state = S_WRAP;
                end else begin
                    o_cmd   = ksc_pkg::CMD_HSTART;
                    n_state = S_HSCAN;
                end
            end
            S_HSCAN: begin
                o_cmd = ksc_pkg::CMD_HSCAN;
                if (i_stat.found) begin
                    n_state = S_HIT_WR;
                end else if (i_stat.scan_done) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                o_cmd   = ksc_pkg::CMD_FSTART;
                n_state = S_FSCAN;
            end
            S_FSCAN: begin
                // Walk went full circle: every active slot has users
                if (i_stat.scan_done) begin
                    o_cmd   = ksc_pkg::CMD_NO_FREE;
                    n_state = S_DONE;
                end else begin
                    o_cmd = ksc_pkg::CMD_FSCAN;
                    if (i_stat.found) begin
                        n_state = S_EVICT;
                    end
                end
            end
            S_HIT_WR: begin
                o_cmd   = ksc_pkg::CMD_HIT_WRITE;
                n_state = S_DONE;
            end
            S_REL_WR: begin
                o_cmd   = ksc_pkg::CMD_REL_WRITE;
                n_state = S_DONE;
            end
            S_EVICT: begin
                o_cmd   = ksc_pkg::CMD_EVICT;
                n_state = S_CLAIM;
            end
            S_CLAIM: begin
                o_cmd   = ksc_pkg::CMD_CLAIM;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd   = ksc_pkg::CMD_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_stall;

endmodule

>>> hdl/ksc_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// ksc_datapath
// Slot store, scan pointer, size multipliers, running total and output
// register of the slot cache. Acts on one command from the controller per
// cycle and reports the flags the controller branches on.
// ============================================================================
module ksc_datapath #(
    parameter int SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration
    input  logic                             i_cfg_we,
    input  logic [ksc_pkg::CFG_W-1:0]        i_cfg_data,
    // Controller
    input  ksc_pkg::t_cmd                    i_cmd,
    output ksc_pkg::t_dp_stat                o_stat,
    // Request fields
    input  logic                             i_op,
    input  logic [ksc_pkg::RANK_W-1:0]       i_rank,
    input  logic [ksc_pkg::BND_W-1:0]        i_boundary,
    input  logic [ksc_pkg::DIM_W-1:0]        i_dim_x,
    input  logic [ksc_pkg::DIM_W-1:0]        i_dim_y,
    input  logic [ksc_pkg::DIM_W-1:0]        i_dim_z,
    input  logic [ksc_pkg::DIM_W-1:0]        i_real_dim_x,
    input  logic [ksc_pkg::DIM_W-1:0]        i_real_dim_y,
    input  logic [ksc_pkg::DIM_W-1:0]        i_real_dim_z,
    input  logic [ksc_pkg::REF_W-1:0]        i_refinement,
    // Result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [2:0]                       o_status,
    output logic [ksc_pkg::SLOT_OUT_W-1:0]   o_slot,
    output logic                             o_evicted,
    output logic [ksc_pkg::TOTAL_W-1:0]      o_total_held
);

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int DW   = ksc_pkg::DIM_W;
    localparam int UW   = ksc_pkg::USE_W;
    localparam int TW   = ksc_pkg::TOTAL_W;
    localparam int SOW  = ksc_pkg::SLOT_OUT_W;
    localparam int P1W  = 2 * DW;
    localparam int P2W  = 3 * DW;

    // Configuration register
    logic [ksc_pkg::CFG_W-1:0]  r_cfg;
    logic [CW-1:0]              act;

    // Latched request
    logic                       r_op;
    logic [ksc_pkg::RANK_W-1:0] r_rank;
    logic [ksc_pkg::BND_W-1:0]  r_bnd;
    logic [DW-1:0]              r_dx;
    logic [DW-1:0]              r_dy;
    logic [DW-1:0]              r_dz;
    logic [DW-1:0]              r_rx;
    logic [DW-1:0]              r_ry;
    logic [DW-1:0]              r_rz;
    logic [ksc_pkg::REF_W-1:0]  r_ref;

    // Size products
    logic [DW-1:0]              size_base;
    logic [DW-1:0]              mul_y;
    logic [DW-1:0]              mul_z;
    logic [P1W-1:0]             r_p1;
    logic [P2W-1:0]             r_p2;
    logic [ksc_pkg::SIZE_W-1:0] r_size;

    // Slot store and its read port
    ksc_pkg::t_entry            r_mem [SLOTS];
    logic [SLOTS-1:0]           r_valid;
    ksc_pkg::t_entry            r_rd_data;
    logic                       r_rd_vld;
    logic [IW-1:0]              r_rd_idx;
    logic [IW-1:0]              rd_addr;
    ksc_pkg::t_entry            rd_ent;

    // Write port
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;
    ksc_pkg::t_entry            mem_wdata;

    // Scan
    logic [IW-1:0]              r_ptr;
    logic [CW-1:0]              r_cnt;
    logic                       r_rv;
    logic [CW-1:0]              ptr_plus;
    logic [IW-1:0]              ptr_next;
    logic                       scan_issue;
    logic                       key_match;
    logic                       match;
    logic                       found;
    logic                       scan_done;
    logic [CW-1:0]              next_adj;

    // Captured slot
    ksc_pkg::t_entry            r_ent;
    logic                       r_ent_vld;
    logic [IW-1:0]              r_sidx;

    // Cache-wide state
    logic [CW-1:0]              r_next;
    logic [IW-1:0]              r_cur;
    logic [TW-1:0]              r_total;

    // Claim checks
    logic                       bad_bnd;
    logic                       bad_ref;
    ksc_pkg::t_status           claim_status;

    // Pending result and output register
    ksc_pkg::t_status           r_res_status;
    logic [IW-1:0]              r_res_slot;
    logic                       r_res_ev;
    logic                       r_out_valid;
    ksc_pkg::t_status           r_out_status;
    logic [SOW-1:0]             r_out_slot;
    logic                       r_out_ev;
    logic [TW-1:0]              r_out_total;

    // Active slot count, clamped to the store depth
    always_comb begin
        if (32'(r_cfg) > SLOTS) begin
            act = CW'(SLOTS);
        end else begin
            act = CW'(r_cfg);
        end
    end

    // Slot as read: a slot not written since reset reads as empty, with an undefined boundary and all else zero
    always_comb begin
        if (r_rd_vld) begin
            rd_ent = r_rd_data;
        end else begin
            rd_ent = '{boundary: ksc_pkg::BND_UNDEF, default: '0};
        end
    end

    assign rd_addr = (i_cmd == ksc_pkg::CMD_REL_READ) ? r_cur : r_ptr;

    // Scan pointer steps round the active slots
    assign ptr_plus   = CW'(r_ptr) + CW'(1);
    assign ptr_next   = (ptr_plus == act) ? '0 : IW'(ptr_plus);
    assign scan_issue = ((i_cmd == ksc_pkg::CMD_HSCAN) || (i_cmd == ksc_pkg::CMD_FSCAN))
                        && (r_cnt != act);

    // Replacement pointer brought back into range before the walk
    always_comb begin
        if (r_next >= act) begin
            next_adj = (act == CW'(1)) ? '0 : CW'(1);
        end else begin
            next_adj = r_next;
        end
    end

    // Hit: same boundary and the first rank dims equal
    assign key_match = (rd_ent.boundary == r_bnd)
                       && ((r_rank < 2'd1) || (rd_ent.dim_x == r_dx))
                       && ((r_rank < 2'd2) || (rd_ent.dim_y == r_dy))
                       && ((r_rank < 2'd3) || (rd_ent.dim_z == r_dz));
    assign match     = (i_cmd == ksc_pkg::CMD_HSCAN) ? key_match
                                                      : (rd_ent.use_count == '0);
    assign found     = r_rv && match;
    assign scan_done = (r_cnt == act) && !r_rv;

    // Boundary and refinement checks of a claim
    assign bad_bnd = (r_bnd == ksc_pkg::BND_TOP_ISO) || (r_bnd == ksc_pkg::BND_UNDEF);
    assign bad_ref = ((r_bnd == ksc_pkg::BND_PERIODIC) && (r_ref != ksc_pkg::REF_UNIT))
                     || ((r_bnd == ksc_pkg::BND_SUB_ISO) && (r_ref <= ksc_pkg::REF_UNIT));

    always_comb begin
        if (bad_bnd) begin
            claim_status = ksc_pkg::ST_BAD_BND;
        end else if (bad_ref) begin
            claim_status = ksc_pkg::ST_BAD_REF;
        end else begin
            claim_status = ksc_pkg::ST_MISS;
        end
    end

    // Size factors: half padded x plus one, then y and z by rank
    assign size_base = {1'b0, r_rx[DW-1:1]} + DW'(1);
    assign mul_y     = (r_rank >= 2'd2) ? r_ry : DW'(1);
    assign mul_z     = (r_rank >= 2'd3) ? r_rz : DW'(1);

    // Write port: hit count up, release count down, claim fill
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sidx;
        mem_wdata = r_ent;
        case (i_cmd)
            ksc_pkg::CMD_HIT_WRITE: begin
                mem_we = 1'b1;
                if (r_ent.use_count != ksc_pkg::USE_MAX) begin
                    mem_wdata.use_count = r_ent.use_count + UW'(1);
                end
            end
            ksc_pkg::CMD_REL_WRITE: begin
                mem_waddr           = r_cur;
                mem_wdata           = rd_ent;
                mem_wdata.use_count = rd_ent.use_count - UW'(1);
                mem_we              = (rd_ent.use_count != '0);
            end
            ksc_pkg::CMD_CLAIM: begin
                mem_we              = 1'b1;
                mem_wdata.boundary  = (claim_status == ksc_pkg::ST_MISS) ? r_bnd
                                                                         : ksc_pkg::BND_UNDEF;
                mem_wdata.use_count = UW'(1);
                mem_wdata.size      = r_size;
                if (r_rank >= 2'd1) begin
                    mem_wdata.dim_x = r_dx;
                end
                if (r_rank >= 2'd2) begin
                    mem_wdata.dim_y = r_dy;
                end
                if (r_rank >= 2'd3) begin
                    mem_wdata.dim_z = r_dz;
                end
            end
            default: begin
            end
        endcase
    end

    // Slot store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= ksc_pkg::CFG_RESET;
            r_valid     <= '0;
            r_next      <= '0;
            r_cur       <= '0;
            r_total     <= '0;
            r_cnt       <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            r_rv <= scan_issue;
            case (i_cmd)
                ksc_pkg::CMD_HSTART: begin
                    r_cnt <= '0;
                end
                ksc_pkg::CMD_FSTART: begin
                    r_cnt  <= '0;
                    r_next <= next_adj;
                end
                ksc_pkg::CMD_HSCAN, ksc_pkg::CMD_FSCAN: begin
                    if (scan_issue) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ksc_pkg::CMD_EVICT: begin
                    // Old size leaves the total; pointer moves past the claim
                    if (r_ent_vld) begin
                        r_total <= r_total - TW'(r_ent.size);
                    end
                    r_next <= CW'(r_sidx) + CW'(1);
                end
                ksc_pkg::CMD_CLAIM: begin
                    r_total <= r_total + TW'(r_size);
                    if (claim_status == ksc_pkg::ST_MISS) begin
                        r_cur <= r_sidx;
                    end
                end
                ksc_pkg::CMD_HIT_WRITE: begin
                    r_cur <= r_sidx;
                end
                default: begin
                end
            endcase
            // Output register valid
            if (i_cmd == ksc_pkg::CMD_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[rd_addr];
        r_rd_idx <= rd_addr;

        // Size product pipeline, runs freely off the latched request
        r_p1 <= P1W'(size_base) * P1W'(mul_y);
        r_p2 <= P2W'(r_p1) * P2W'(mul_z);
        if (r_p2 > P2W'(ksc_pkg::SIZE_MAX)) begin
            r_size <= ksc_pkg::SIZE_MAX;
        end else begin
            r_size <= r_p2[ksc_pkg::SIZE_W-1:0];
        end

        case (i_cmd)
            ksc_pkg::CMD_LOAD: begin
                r_op   <= i_op;
                r_rank <= i_rank;
                r_bnd  <= i_boundary;
                r_dx   <= i_dim_x;
                r_dy   <= i_dim_y;
                r_dz   <= i_dim_z;
                r_rx   <= i_real_dim_x;
                r_ry   <= i_real_dim_y;
                r_rz   <= i_real_dim_z;
                r_ref  <= i_refinement;
            end
            ksc_pkg::CMD_HSTART: begin
                r_ptr <= '0;
            end
            ksc_pkg::CMD_FSTART: begin
                r_ptr <= IW'(next_adj);
            end
            ksc_pkg::CMD_HSCAN, ksc_pkg::CMD_FSCAN: begin
                if (scan_issue) begin
                    r_ptr <= ptr_next;
                end
                if (found) begin
                    r_ent     <= rd_ent;
                    r_ent_vld <= r_rd_vld;
                    r_sidx    <= r_rd_idx;
                end
            end
            ksc_pkg::CMD_HIT_WRITE: begin
                r_res_status <= ksc_pkg::ST_HIT;
                r_res_slot   <= r_sidx;
                r_res_ev     <= 1'b0;
            end
            ksc_pkg::CMD_REL_WRITE: begin
                r_res_status <= ksc_pkg::ST_RELEASE;
                r_res_slot   <= r_cur;
                r_res_ev     <= 1'b0;
            end
            ksc_pkg::CMD_CLAIM: begin
                r_res_status <= claim_status;
                r_res_slot   <= r_sidx;
                r_res_ev     <= r_ent_vld;
            end
            ksc_pkg::CMD_NO_FREE: begin
                r_res_status <= ksc_pkg::ST_NO_FREE;
                r_res_slot   <= '0;
                r_res_ev     <= 1'b0;
            end
            ksc_pkg::CMD_NO_CAP: begin
                r_res_status <= ksc_pkg::ST_NO_CAP;
                r_res_slot   <= '0;
                r_res_ev     <= 1'b0;
            end
            ksc_pkg::CMD_PUSH: begin
                r_out_status <= r_res_status;
                r_out_slot   <= SOW'(r_res_slot);
                r_out_ev     <= r_res_ev;
                r_out_total  <= r_total;
            end
            default: begin
            end
        endcase
    end

    // Flags to the controller
    assign o_stat.is_release = (r_op == ksc_pkg::OP_RELEASE);
    assign o_stat.bnd_undef  = (r_bnd == ksc_pkg::BND_UNDEF);
    assign o_stat.act_zero   = (act == '0);
    assign o_stat.found      = found;
    assign o_stat.scan_done  = scan_done;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot       = r_out_slot;
    assign o_evicted    = r_out_ev;
    assign o_total_held = r_out_total;

`ifndef ASSERT_OFF
    // A claimed slot was free and lies inside the active range
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == ksc_pkg::CMD_CLAIM) |-> ((r_ent.use_count == '0) && (CW'(r_sidx) < act)))
        else $error("claim of a slot that has users or is out of range");

    // A hit carries the request's own, defined boundary
    a_hit_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == ksc_pkg::CMD_HIT_WRITE)
            |-> ((r_ent.boundary == r_bnd) && (r_bnd != ksc_pkg::BND_UNDEF)))
        else $error("hit on a slot with a different or undefined boundary");

    // Replacement pointer never goes past one beyond the last slot
    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next <= CW'(SLOTS)))
        else $error("replacement pointer out of range");

    // Only a filled slot can have users to release
    a_rel_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd == ksc_pkg::CMD_REL_WRITE) && (rd_ent.use_count != '0)) |-> r_rd_vld)
        else $error("release found users on an unfilled slot");
`endif

endmodule

>>> hdl/kernel_slot_cache_top.sv
`timescale 1ns / 1ps
// ============================================================================
// kernel_slot_cache_top
// Reference-counted round-robin cache of kernel slots keyed by boundary type
// and grid dimensions.
// ============================================================================
// Usage:
//   Request channel i_in_valid / o_in_stall carries a prepare (op 0) or a
//   release (op 1). Each request gives exactly one result on o_out_valid /
//   i_out_stall: status, slot, evicted flag and the total held size.
//   i_cfg_we writes active_slots; do so only while no request is in flight.
//   One request is worked at a time. A release steps down the count of the
//   slot last hit or claimed. A prepare with zero capacity gets no scan;
//   else it scans the slots for a hit and on a miss walks from the
//   replacement pointer to a free slot, or reports that none is free. An
//   undefined boundary skips the hit scan. Both scans read the slot store
//   one entry a cycle through its one read port. The request channel
//   reopens as the result enters the output register, even while that
//   result is stalled.
//   A stalled result holds in the output register; a further result waits
//   in the sequencer until it drains.
//   Reset (synchronous, active low) empties every slot, clears the total and
//   pointers and sets active_slots to 16; no clearing pass is needed.
// ============================================================================
module kernel_slot_cache_top #(
    parameter int SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration
    input  logic                             i_cfg_we,
    input  logic [ksc_pkg::CFG_W-1:0]        i_cfg_data,
    // Request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic [ksc_pkg::RANK_W-1:0]       i_rank,
    input  logic [ksc_pkg::BND_W-1:0]        i_boundary,
    input  logic [ksc_pkg::DIM_W-1:0]        i_dim_x,
    input  logic [ksc_pkg::DIM_W-1:0]        i_dim_y,
    input  logic [ksc_pkg::DIM_W-1:0]        i_dim_z,
    input  logic [ksc_pkg::DIM_W-1:0]        i_real_dim_x,
    input  logic [ksc_pkg::DIM_W-1:0]        i_real_dim_y,
    input  logic [ksc_pkg::DIM_W-1:0]        i_real_dim_z,
    input  logic [ksc_pkg::REF_W-1:0]        i_refinement,
    // Result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [2:0]                       o_status,
    output logic [ksc_pkg::SLOT_OUT_W-1:0]   o_slot,
    output logic                             o_evicted,
    output logic [ksc_pkg::TOTAL_W-1:0]      o_total_held
);

    ksc_pkg::t_cmd     cmd;
    ksc_pkg::t_dp_stat stat;

    // Sequencer
    ksc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Slot store, arithmetic and output register
    ksc_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_op),
        .i_rank       (i_rank),
        .i_boundary   (i_boundary),
        .i_dim_x      (i_dim_x),
        .i_dim_y      (i_dim_y),
        .i_dim_z      (i_dim_z),
        .i_real_dim_x (i_real_dim_x),
        .i_real_dim_y (i_real_dim_y),
        .i_real_dim_z (i_real_dim_z),
        .i_refinement (i_refinement),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_evicted    (o_evicted),
        .o_total_held (o_total_held)
    );

endmodule
